### rtl/core/rfla_pkg.sv
package rfla_pkg;

   // Default number of registers handed out by the allocator.
   localparam int NUM_REGS_DEF = 64;

   // Fixed widths of the channel fields.
   localparam int CMD_W   = 2;
   localparam int FIELD_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT,
      ST_EMIT_SWEEP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep_step;
      logic sweep_init;
      logic accept_alloc;
      logic do_free;
      logic grant_none;
      logic load_head;
      logic load_out;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic head_valid;
      logic out_free;
      logic sweep_last;
   } status_type;

endpackage

### rtl/core/rfla_channels.sv
interface rfla_req_if;
   import rfla_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic signed [FIELD_W-1:0]  free_index;

   modport source (output valid, output command, output free_index, input ready);
   modport sink (input valid, input command, input free_index, output ready);
endinterface

interface rfla_rsp_if;
   import rfla_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [FIELD_W-1:0]  granted_index;
   logic [FIELD_W-1:0]         registers_used;

   modport source (output valid, output granted_index, output registers_used, input ready);
   modport sink (input valid, input granted_index, input registers_used, output ready);
endinterface

### rtl/core/rfla_ram.sv
module rfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rfla_datapath.sv
module rfla_datapath #(
   parameter int NUM_REGS = rfla_pkg::NUM_REGS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rfla_pkg::ctl_type                  ctl,
   output rfla_pkg::status_type               status,
   input  logic signed [rfla_pkg::FIELD_W-1:0] free_index,
   output logic signed [rfla_pkg::FIELD_W-1:0] granted_index,
   output logic [rfla_pkg::FIELD_W-1:0]       registers_used,
   output logic                               rsp_valid,
   input  logic                               rsp_ready
);
   import rfla_pkg::*;

   localparam int IDX_W  = $clog2(NUM_REGS);
   localparam int LINK_W = IDX_W + 1;
   localparam int CMP_W  = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 1;
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_REGS - 1);
   localparam logic [LINK_W-1:0] END_LINK = LINK_W'(1) << IDX_W;

   logic              head_valid_ff, head_valid_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  hw_ff, hw_in;
   logic              grant_valid_ff, grant_valid_in;
   logic [IDX_W-1:0]  grant_ff, grant_in;
   logic [IDX_W-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] granted_ff, granted_in;
   logic [FIELD_W-1:0] used_ff, used_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic [LINK_W-1:0] rd_data;

   logic [CMP_W-1:0]  idx_ext;
   logic [IDX_W-1:0]  free_idx;
   logic              free_in_range;

   // Each entry holds an end flag above the index of the next free register.
   rfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NUM_REGS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign idx_ext       = CMP_W'(free_index[FIELD_W-2:0]);
   assign free_idx      = idx_ext[IDX_W-1:0];
   assign free_in_range = !free_index[FIELD_W-1] && (idx_ext < CMP_W'(NUM_REGS));

   always_comb begin
      head_valid_in  = head_valid_ff;
      head_in        = head_ff;
      hw_in          = hw_ff;
      grant_valid_in = grant_valid_ff;
      grant_in       = grant_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      wr_en          = 1'b0;
      wr_addr        = sweep_cnt_ff;
      wr_data        = END_LINK;

      if (ctl.sweep_step) begin
         wr_en = 1'b1;
         if (sweep_cnt_ff == LAST_IDX) begin
            wr_data      = END_LINK;
            sweep_cnt_in = '0;
         end else begin
            wr_data      = {1'b0, sweep_cnt_ff + 1'b1};
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
         end
      end

      if (ctl.sweep_init) begin
         head_valid_in = 1'b1;
         head_in       = '0;
         hw_in         = '0;
         sweep_cnt_in  = '0;
      end

      if (ctl.grant_none) begin
         grant_valid_in = 1'b0;
      end

      if (ctl.accept_alloc) begin
         grant_valid_in = head_valid_ff;
         grant_in       = head_ff;
         if (head_valid_ff && (head_ff > hw_ff)) begin
            hw_in = head_ff;
         end
      end

      // An empty list links the pushed entry to the end marker.
      if (ctl.do_free && free_in_range) begin
         wr_en         = 1'b1;
         wr_addr       = free_idx;
         wr_data       = {!head_valid_ff, head_ff};
         head_valid_in = 1'b1;
         head_in       = free_idx;
      end

      if (ctl.load_head) begin
         head_valid_in = !rd_data[IDX_W];
         head_in       = rd_data[IDX_W-1:0];
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      granted_in   = granted_ff;
      used_in      = used_ff;
      if (ctl.load_out) begin
         rsp_valid_in = 1'b1;
         granted_in   = grant_valid_in ? FIELD_W'(grant_in) : {FIELD_W{1'b1}};
         used_in      = FIELD_W'({1'b0, hw_in} + LINK_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff  <= 1'b1;
         head_ff        <= '0;
         hw_ff          <= '0;
         grant_valid_ff <= 1'b0;
         sweep_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         head_valid_ff  <= head_valid_in;
         head_ff        <= head_in;
         hw_ff          <= hw_in;
         grant_valid_ff <= grant_valid_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      grant_ff   <= grant_in;
      granted_ff <= granted_in;
      used_ff    <= used_in;
   end

   assign status.head_valid = head_valid_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.sweep_last = (sweep_cnt_ff == LAST_IDX);

   assign rsp_valid      = rsp_valid_ff;
   assign granted_index  = granted_ff;
   assign registers_used = used_ff;

`ifndef SYNTHESIS
   a_clear_zeroes_mark: assert property (@(posedge clock) disable iff (reset)
      ctl.sweep_init |=> (hw_ff == '0))
      else $error("high-water mark not cleared by a clear command");

   a_mark_covers_grant: assert property (@(posedge clock) disable iff (reset)
      (ctl.accept_alloc && head_valid_ff) |=> (hw_ff >= $past(head_ff)))
      else $error("high-water mark below a granted index");

   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.accept_alloc && head_valid_ff) |=> (32'(grant_ff) < NUM_REGS))
      else $error("granted index out of range");
`endif

endmodule

### rtl/core/rfla_controller.sv
module rfla_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  rfla_pkg::cmd_type    req_command,
   output logic                 req_ready,
   input  rfla_pkg::status_type status,
   output rfla_pkg::ctl_type    ctl
);
   import rfla_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            ctl.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_command)
                  CMD_ALLOC: begin
                     ctl.accept_alloc = 1'b1;
                     if (status.head_valid) begin
                        state_in = ST_LOOKUP;
                     end else if (status.out_free) begin
                        ctl.load_out = 1'b1;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  CMD_FREE: begin
                     ctl.do_free    = 1'b1;
                     ctl.grant_none = 1'b1;
                     if (status.out_free) begin
                        ctl.load_out = 1'b1;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  CMD_CLEAR: begin
                     ctl.sweep_init = 1'b1;
                     ctl.grant_none = 1'b1;
                     if (status.out_free) begin
                        ctl.load_out = 1'b1;
                        state_in     = ST_SWEEP;
                     end else begin
                        state_in = ST_EMIT_SWEEP;
                     end
                  end
                  default: begin
                     ctl.grant_none = 1'b1;
                     if (status.out_free) begin
                        ctl.load_out = 1'b1;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            ctl.load_head = 1'b1;
            if (status.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_SWEEP: begin
            if (status.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = ST_SWEEP;
            end
         end
      endcase
   end

`ifndef SYNTHESIS
   a_head_after_alloc: assert property (@(posedge clock) disable iff (reset)
      ctl.load_head |-> $past(ctl.accept_alloc))
      else $error("head reloaded without a preceding allocate");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> status.out_free)
      else $error("result loaded over one still waiting");

   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == ST_SWEEP))
      else $error("link sweep not started after reset");
`endif

endmodule

### rtl/core/register_free_list_allocator.sv
// Channel   Dir  Handshake     Payload
// req_ch    in   valid/ready   command, free_index
// rsp_ch    out  valid/ready   granted_index, registers_used
//
// An allocate that finds a register first reads the link at the head from the link memory,
// then loads the new head and, once the output register is free, the result register.
// Free, unknown commands and an allocate on an empty list skip the read of the link memory.
// A clear, and reset, sweep the link memory one entry per cycle through every entry,
// during which no item is accepted.
// A stalled result stays in the output register; the next item is still accepted and
// its result waits in the block until the output register is free.
module register_free_list_allocator #(
   parameter int NUM_REGS = rfla_pkg::NUM_REGS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   rfla_req_if.sink     req_ch,
   rfla_rsp_if.source   rsp_ch
);
   import rfla_pkg::*;

   ctl_type    ctl;
   status_type status;

   // The controller sequences each item; the datapath keeps the list head, the
   // high-water mark, the link memory and the output register.
   rfla_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (cmd_type'(req_ch.command)),
      .req_ready   (req_ch.ready),
      .status      (status),
      .ctl         (ctl)
   );

   rfla_datapath #(
      .NUM_REGS (NUM_REGS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .status         (status),
      .free_index     (req_ch.free_index),
      .granted_index  (rsp_ch.granted_index),
      .registers_used (rsp_ch.registers_used),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready)
   );

endmodule
